>>> rtl/core/cdiv_pkg.sv
// Shared types, constants and helpers for the complex divider.
package cdiv_pkg;

	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int RATIO_W = 30;
	localparam int WIDE_W  = 34;
	localparam int QUO_W   = 34;
	localparam int REM_W   = 64;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic OP_DIV   = 1'b0;
	localparam logic OP_RECIP = 1'b1;

	typedef struct packed {
		logic                     operation;
		logic signed [DATA_W-1:0] num_re;
		logic signed [DATA_W-1:0] num_im;
		logic signed [DATA_W-1:0] den_re;
		logic signed [DATA_W-1:0] den_im;
	} cdiv_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quot_re;
		logic signed [DATA_W-1:0] quot_im;
		logic [1:0]               status;
	} cdiv_out_t;

	typedef struct packed {
		logic                     zero;
		logic                     swap;
		logic signed [DATA_W-1:0] big;
		logic signed [DATA_W-1:0] minor;
		logic signed [DATA_W-1:0] nre;
		logic signed [DATA_W-1:0] nim;
	} side_t;

	typedef struct packed {
		logic             neg;
		logic [REM_W-1:0] a_mag;
		logic [QUO_W-1:0] b_mag;
		side_t            side;
	} div_in_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [QUO_W-1:0] quo;
		side_t            side;
	} div_out_t;

	// x / 2^RATIO_W, truncated toward zero
	function automatic logic signed [WIDE_W-1:0] rscale(input logic signed [63:0] x);
		logic signed [63:0] t;
		begin
			t = x[63] ? (x + 64'sd1073741823) : x;
			t = t >>> RATIO_W;
			return t[WIDE_W-1:0];
		end
	endfunction

	function automatic logic [WIDE_W-1:0] mag34(input logic signed [WIDE_W-1:0] x);
		return x[WIDE_W-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

>>> rtl/core/cdiv_divider.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module cdiv_divider import cdiv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  div_in_t  in_beat,
	output logic     out_valid,
	output div_out_t out_beat
);

	logic             vld_s  [0:QUO_W];
	logic [REM_W-1:0] rem_s  [0:QUO_W];
	logic [QUO_W-1:0] quo_s  [0:QUO_W];
	logic [QUO_W-1:0] b_s    [0:QUO_W];
	logic             neg_s  [0:QUO_W];
	logic             ovf_s  [0:QUO_W];
	side_t            side_s [0:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= in_beat.a_mag;
		quo_s[0]  <= '0;
		b_s[0]    <= in_beat.b_mag;
		neg_s[0]  <= in_beat.neg;
		side_s[0] <= in_beat.side;
		ovf_s[0]  <= {4'b0, in_beat.a_mag} >= {in_beat.b_mag, {QUO_W{1'b0}}};
	end

	genvar k;
	for (k = 1; k <= QUO_W; k++) begin : g_stage
		localparam int BIT = QUO_W - k;
		logic [REM_W+3:0] sh;
		logic             take;
		assign sh   = {{(REM_W+4-QUO_W){1'b0}}, b_s[k-1]} << BIT;
		assign take = {4'b0, rem_s[k-1]} >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? (rem_s[k-1] - sh[REM_W-1:0]) : rem_s[k-1];
			quo_s[k]  <= quo_s[k-1] | (QUO_W'(take) << BIT);
			b_s[k]    <= b_s[k-1];
			neg_s[k]  <= neg_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid     = vld_s[QUO_W];
	assign out_beat.neg  = neg_s[QUO_W];
	assign out_beat.ovf  = ovf_s[QUO_W];
	assign out_beat.quo  = quo_s[QUO_W];
	assign out_beat.side = side_s[QUO_W];

endmodule

>>> rtl/core/complex_divide.sv
// Top level: pipelined complex division by Smith's scaled method.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------
//  command  | start, busy, cmd       | beat taken when start && !busy
//  result   | done, result           | one-cycle strobe, no backpressure
//
// One beat enters every cycle; busy is always low.
// Path: input register, ratio divider, multiply and sum stages, two parallel
// quotient dividers, output register. Dividers have 35 stages each.
// Reset clears only the valid bits; payload registers are not reset.
module complex_divide import cdiv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cdiv_in_t  cmd,
	output logic      done,
	output cdiv_out_t result
);

	assign busy = 1'b0;

	// stage 1: capture, numerator select
	logic                     v_s1;
	logic signed [DATA_W-1:0] nre_s1, nim_s1, dre_s1, dim_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (cmd.operation == OP_RECIP) begin
			nre_s1 <= DATA_W'(1) <<< FRAC_W;
			nim_s1 <= '0;
		end else begin
			nre_s1 <= cmd.num_re;
			nim_s1 <= cmd.num_im;
		end
		dre_s1 <= cmd.den_re;
		dim_s1 <= cmd.den_im;
	end

	// ratio divider
	logic [DATA_W-1:0] mre, mim, mbig, mminor;
	logic              swap;
	div_in_t           rin;
	div_out_t          rout;
	logic              rv;

	assign mre    = dre_s1[DATA_W-1] ? (~dre_s1 + 1'b1) : dre_s1;
	assign mim    = dim_s1[DATA_W-1] ? (~dim_s1 + 1'b1) : dim_s1;
	assign swap   = mre < mim;
	assign mbig   = swap ? mim : mre;
	assign mminor = swap ? mre : mim;

	assign rin.neg        = dre_s1[DATA_W-1] ^ dim_s1[DATA_W-1];
	assign rin.a_mag      = {2'b0, mminor, {RATIO_W{1'b0}}};
	assign rin.b_mag      = {2'b0, mbig};
	assign rin.side.zero  = (dre_s1 == '0) && (dim_s1 == '0);
	assign rin.side.swap  = swap;
	assign rin.side.big   = swap ? dim_s1 : dre_s1;
	assign rin.side.minor = swap ? dre_s1 : dim_s1;
	assign rin.side.nre   = nre_s1;
	assign rin.side.nim   = nim_s1;

	cdiv_divider u_ratio (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s1), .in_beat(rin),
		.out_valid(rv), .out_beat(rout)
	);

	// stage 3: products with r
	logic signed [DATA_W-1:0] r;
	assign r = rout.neg ? -$signed(rout.quo[DATA_W-1:0]) : $signed(rout.quo[DATA_W-1:0]);

	logic               v_s3;
	logic signed [63:0] pd_s3, pre_s3, pim_s3;
	side_t              side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= rv;
	end

	always_ff @(posedge clk) begin
		pd_s3   <= rout.side.minor * r;
		pre_s3  <= rout.side.nre * r;
		pim_s3  <= rout.side.nim * r;
		side_s3 <= rout.side;
	end

	// stage 4: den, p, q
	logic signed [WIDE_W-1:0] td, tre, tim, big_x, nre_x, nim_x;
	logic                     v_s4, zero_s4;
	logic signed [WIDE_W-1:0] den_s4, p_s4, q_s4;

	assign td    = rscale(pd_s3);
	assign tre   = rscale(pre_s3);
	assign tim   = rscale(pim_s3);
	assign big_x = WIDE_W'(side_s3.big);
	assign nre_x = WIDE_W'(side_s3.nre);
	assign nim_x = WIDE_W'(side_s3.nim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		den_s4  <= big_x + td;
		zero_s4 <= side_s3.zero;
		if (side_s3.swap) begin
			p_s4 <= tre + nim_x;
			q_s4 <= tim - nre_x;
		end else begin
			p_s4 <= nre_x + tim;
			q_s4 <= nim_x - tre;
		end
	end

	// quotient dividers
	div_in_t  pin, qin;
	div_out_t pout, qout;
	logic     pv, qv;
	logic [WIDE_W-1:0] mden;

	assign mden = mag34(den_s4);

	assign pin.neg       = p_s4[WIDE_W-1] ^ den_s4[WIDE_W-1];
	assign pin.a_mag     = {14'b0, mag34(p_s4), {FRAC_W{1'b0}}};
	assign pin.b_mag     = mden;
	assign pin.side      = '{zero: zero_s4, swap: 1'b0, default: '0};
	assign qin.neg       = q_s4[WIDE_W-1] ^ den_s4[WIDE_W-1];
	assign qin.a_mag     = {14'b0, mag34(q_s4), {FRAC_W{1'b0}}};
	assign qin.b_mag     = mden;
	assign qin.side      = '0;

	cdiv_divider u_quot_re (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s4), .in_beat(pin),
		.out_valid(pv), .out_beat(pout)
	);

	cdiv_divider u_quot_im (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s4), .in_beat(qin),
		.out_valid(qv), .out_beat(qout)
	);

	// sign and clamp
	localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(34'h07FFFFFFF);
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(34'h080000000);

	logic signed [DATA_W-1:0] vre, vim;
	logic                     sre, sim;

	always_comb begin
		if (pout.neg) begin
			sre = pout.ovf || (pout.quo > NEG_LIM);
			vre = sre ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed(pout.quo[DATA_W-1:0]);
		end else begin
			sre = pout.ovf || (pout.quo > POS_LIM);
			vre = sre ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(pout.quo[DATA_W-1:0]);
		end
		if (qout.neg) begin
			sim = qout.ovf || (qout.quo > NEG_LIM);
			vim = sim ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed(qout.quo[DATA_W-1:0]);
		end else begin
			sim = qout.ovf || (qout.quo > POS_LIM);
			vim = sim ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(qout.quo[DATA_W-1:0]);
		end
	end

	cdiv_out_t res_q;
	logic      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= pv;
	end

	always_ff @(posedge clk) begin
		if (pout.side.zero) begin
			res_q.quot_re <= '0;
			res_q.quot_im <= '0;
			res_q.status  <= ST_ZERO;
		end else begin
			res_q.quot_re <= vre;
			res_q.quot_im <= vim;
			res_q.status  <= (sre || sim) ? ST_SAT : ST_OK;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		pv == qv) else $error("quotient dividers out of step");

	a_zero_parts: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_ZERO |-> result.quot_re == '0 && result.quot_im == '0)
		else $error("zero divisor with nonzero parts");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status == ST_OK || result.status == ST_SAT ||
		result.status == ST_ZERO) else $error("bad status code");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(pv)) else $error("result without a beat in flight");

endmodule
